// ===== hdl/awk_pkg.sv =====
// Package for the alpha blend with white keying block.
// Holds field widths, register indexes, reset values and the stage word type.
// Depends on nothing.
package awk_pkg;

    localparam int PIXEL_W     = 32;
    localparam int BLEND_W     = 24;
    localparam int CHAN_W      = 8;
    localparam int RATE_W      = 12;
    localparam int CFG_IDX_W   = 1;
    localparam int SUM_W       = 10;
    localparam int PROD_W      = 18;
    localparam int NUM_W       = 30;
    localparam int QUOT_W      = 14;
    localparam int RECIP_W     = 10;
    localparam int RECIP_PROD_W = QUOT_W + RECIP_W;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_RATE   = 1'd1;

    localparam logic [RATE_W-1:0]  KEY_RATE_RESET = 12'd307;
    localparam logic [SUM_W-1:0]   KEY_SUM_TOP    = 10'd768;
    localparam logic [QUOT_W-1:0]  KEY_CLAMP_Q    = 14'd768;
    localparam logic [RECIP_W-1:0] THIRD_RECIP    = 10'd683;
    localparam int                 THIRD_SHIFT    = 11;
    localparam logic [CHAN_W-1:0]  CHAN_MAX       = 8'd255;

    typedef struct packed {
        logic                valid;
        logic [CHAN_W-1:0]   alpha;
        logic [PIXEL_W-1:0]  dest;
        logic [PIXEL_W-1:0]  source;
    } mix_word_t;

endpackage

// ===== hdl/awk_key.sv =====
// Key alpha pipeline: channel sum, gain multiply, divide by three, alpha pick.
// Four register stages; hands a mix_word_t to the blend stage.
// Depends on awk_pkg.
module awk_key
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [awk_pkg::PIXEL_W-1:0]      dest_pixel,
    input  logic [awk_pkg::PIXEL_W-1:0]      source_pixel,
    input  logic                             key_enable,
    input  logic [awk_pkg::RATE_W-1:0]       key_rate,
    output awk_pkg::mix_word_t               mix_word
);

    logic [2:0]                         valid_reg;
    logic [awk_pkg::PIXEL_W-1:0]        dest_reg   [3];
    logic [awk_pkg::PIXEL_W-1:0]        source_reg [3];
    logic [awk_pkg::SUM_W-1:0]          inv_sum_reg;
    logic [awk_pkg::PROD_W-1:0]         prod_reg;
    logic [awk_pkg::QUOT_W-1:0]         quot_reg;
    logic [awk_pkg::SUM_W-1:0]          sum_next;
    logic [awk_pkg::PROD_W-1:0]         prod_next;
    logic [awk_pkg::NUM_W-1:0]          num_next;
    logic [awk_pkg::RECIP_PROD_W-1:0]   recip_prod;
    logic [awk_pkg::CHAN_W-1:0]         key_next;
    logic [awk_pkg::CHAN_W-1:0]         alpha_next;
    logic [awk_pkg::CHAN_W-1:0]         src_alpha;
    logic                               mix_valid_reg;
    logic [awk_pkg::CHAN_W-1:0]         mix_alpha_reg;
    logic [awk_pkg::PIXEL_W-1:0]        mix_dest_reg;
    logic [awk_pkg::PIXEL_W-1:0]        mix_source_reg;

    always_comb
    begin
        sum_next   = awk_pkg::SUM_W'(source_pixel[7:0])
                   + awk_pkg::SUM_W'(source_pixel[15:8])
                   + awk_pkg::SUM_W'(source_pixel[23:16]);
        prod_next  = {inv_sum_reg, 8'd0} - awk_pkg::PROD_W'(inv_sum_reg);
        num_next   = awk_pkg::NUM_W'(prod_reg) * awk_pkg::NUM_W'(key_rate);
        recip_prod = awk_pkg::RECIP_PROD_W'(quot_reg)
                   * awk_pkg::RECIP_PROD_W'(awk_pkg::THIRD_RECIP);
        if (quot_reg >= awk_pkg::KEY_CLAMP_Q)
        begin
            key_next = awk_pkg::CHAN_MAX;
        end
        else
        begin
            key_next = recip_prod[awk_pkg::THIRD_SHIFT +: awk_pkg::CHAN_W];
        end
        src_alpha  = source_reg[2][31:24];
        alpha_next = src_alpha;
        if (key_enable && (key_next < src_alpha))
        begin
            alpha_next = key_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            mix_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= {valid_reg[1:0], in_valid};
            mix_valid_reg <= valid_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        inv_sum_reg   <= awk_pkg::KEY_SUM_TOP - sum_next;
        dest_reg[0]   <= dest_pixel;
        source_reg[0] <= source_pixel;
        prod_reg      <= prod_next;
        dest_reg[1]   <= dest_reg[0];
        source_reg[1] <= source_reg[0];
        quot_reg      <= num_next[awk_pkg::NUM_W-1 -: awk_pkg::QUOT_W];
        dest_reg[2]   <= dest_reg[1];
        source_reg[2] <= source_reg[1];
        mix_alpha_reg  <= alpha_next;
        mix_dest_reg   <= dest_reg[2];
        mix_source_reg <= source_reg[2];
    end

    assign mix_word = '{valid:  mix_valid_reg,
                        alpha:  mix_alpha_reg,
                        dest:   mix_dest_reg,
                        source: mix_source_reg};

endmodule

// ===== hdl/awk_mix.sv =====
// Blend stage: per channel dst*(255-a) + src*a, keep the high byte.
// One register stage feeding the result port; depends on awk_pkg.
module awk_mix
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  awk_pkg::mix_word_t               mix_word,
    output logic                             out_valid,
    output logic [awk_pkg::BLEND_W-1:0]      out_pixel
);

    localparam int MIX_W = 2 * awk_pkg::CHAN_W + 1;

    logic                           valid_reg;
    logic [awk_pkg::BLEND_W-1:0]    pixel_reg;
    logic [awk_pkg::BLEND_W-1:0]    pixel_next;
    logic [awk_pkg::CHAN_W-1:0]     inv_alpha;
    logic [MIX_W-1:0]               chan_sum [3];

    always_comb
    begin
        inv_alpha = awk_pkg::CHAN_MAX - mix_word.alpha;
        for (int i = 0; i < 3; i++)
        begin
            chan_sum[i] = MIX_W'(mix_word.dest[8*i +: 8] * inv_alpha)
                        + MIX_W'(mix_word.source[8*i +: 8] * mix_word.alpha);
            pixel_next[8*i +: 8] = chan_sum[i][awk_pkg::CHAN_W +: awk_pkg::CHAN_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= mix_word.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
    end

    assign out_valid = valid_reg;
    assign out_pixel = pixel_reg;

endmodule

// ===== hdl/alpha_blend_white_key.sv =====
// Top level of the alpha blend with white keying block.
// Holds the configuration registers; instantiates awk_key and awk_mix; uses awk_pkg.
//
// One word in per clock: busy stays low, so every cycle with start high takes a
// pixel pair. The blended pixel shows on blended_pixel with done high and lasts
// one cycle; the receiver cannot stall it. The path is the key pipeline (channel
// sum, times 255, times rate, divide by three and pick alpha) and one blend stage.
// Write the registers only while no word is in flight.
module alpha_blend_white_key
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    output logic                             done,
    input  logic [awk_pkg::PIXEL_W-1:0]      dest_pixel,
    input  logic [awk_pkg::PIXEL_W-1:0]      source_pixel,
    output logic [awk_pkg::BLEND_W-1:0]      blended_pixel,
    input  logic                             cfg_we,
    input  logic [awk_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [awk_pkg::RATE_W-1:0]       cfg_data
);

    logic                           key_enable_reg;
    logic [awk_pkg::RATE_W-1:0]     key_rate_reg;
    awk_pkg::mix_word_t             mix_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_enable_reg <= 1'b0;
            key_rate_reg   <= awk_pkg::KEY_RATE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                awk_pkg::REG_KEY_ENABLE: key_enable_reg <= cfg_data[0];
                awk_pkg::REG_KEY_RATE:   key_rate_reg   <= cfg_data;
                default:                 ;
            endcase
        end
    end

    assign busy = 1'b0;

    awk_key u_key
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start && !busy),
        .dest_pixel   (dest_pixel),
        .source_pixel (source_pixel),
        .key_enable   (key_enable_reg),
        .key_rate     (key_rate_reg),
        .mix_word     (mix_word)
    );

    awk_mix u_mix
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .mix_word  (mix_word),
        .out_valid (done),
        .out_pixel (blended_pixel)
    );

`ifndef SYNTHESIS
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 5))
        else $error("done without a word taken five cycles earlier");

    a_alpha_not_above_source: assert property (@(posedge clk) disable iff (!rst_n)
        mix_word.valid |-> (mix_word.alpha <= mix_word.source[31:24]))
        else $error("blend alpha exceeds source alpha");

    a_alpha_plain_when_unkeyed: assert property (@(posedge clk) disable iff (!rst_n)
        (mix_word.valid && !key_enable_reg)
            |-> (mix_word.alpha == mix_word.source[31:24]))
        else $error("alpha differs from source alpha with keying off");
`endif

endmodule
